### rtl/tuab_pkg.sv
`default_nettype none
package tuab_pkg;

  localparam int VALUE_BITS = 64;
  localparam int POSITION_BITS = 16;
  localparam int BASE_BITS = 6;
  localparam int CHAR_BITS = 8;
  localparam int STATUS_BITS = 2;
  localparam int PROD_BITS = VALUE_BITS + BASE_BITS + 1;
  localparam int RESULT_BITS = VALUE_BITS + POSITION_BITS + STATUS_BITS;
  localparam int TDATA_BITS = ((RESULT_BITS + 7) / 8) * 8;

  localparam logic [BASE_BITS-1:0] BASE_OCT = BASE_BITS'(8);
  localparam logic [BASE_BITS-1:0] BASE_DEC = BASE_BITS'(10);
  localparam logic [BASE_BITS-1:0] BASE_HEX = BASE_BITS'(16);
  localparam logic [BASE_BITS-1:0] BASE_MAX = BASE_BITS'(36);
  localparam logic [BASE_BITS-1:0] NOT_DIGIT = '1;
  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  localparam logic [CHAR_BITS-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_BITS-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_BITS-1:0] CH_CR    = 8'h0d;
  localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_BITS-1:0] CH_PLUS  = 8'h2b;
  localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_BITS-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_BITS-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_BITS-1:0] CH_UZ    = 8'h5a;
  localparam logic [CHAR_BITS-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_BITS-1:0] CH_LZ    = 8'h7a;
  localparam logic [CHAR_BITS-1:0] CH_UX    = 8'h58;
  localparam logic [CHAR_BITS-1:0] CH_LX    = 8'h78;
  localparam logic [CHAR_BITS-1:0] UPPER_OFS = CH_UA - 8'd10;
  localparam logic [CHAR_BITS-1:0] LOWER_OFS = CH_LA - 8'd10;

  typedef enum logic [2:0] {
    PH_SPACE,
    PH_FIRST,
    PH_ZERO,
    PH_HEXPFX,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_NODIGITS = 2'd2
  } status_code_t;

  typedef enum logic [1:0] {
    BASE_FROM_REG,
    BASE_SET_OCT,
    BASE_SET_HEX
  } base_src_t;

  typedef enum logic {
    EMIT_FINISH,
    EMIT_OVERFLOW
  } emit_kind_t;

  typedef struct packed {
    logic       restart;
    logic       step;
    logic       use_first_base;
    logic       set_sign;
    logic       load_base;
    base_src_t  base_src;
    logic       mark_zero;
    logic       take;
    logic       emit;
    emit_kind_t emit_kind;
  } dp_cmd_t;

  typedef struct packed {
    logic is_nul;
    logic is_space;
    logic is_sign;
    logic is_zero_ch;
    logic is_x;
    logic nb_zero;
    logic nb_hex;
    logic digit_ok;
    logic overflow;
  } dp_status_t;

  function automatic logic [BASE_BITS-1:0] digit_of(input logic [CHAR_BITS-1:0] ch);
    logic [CHAR_BITS-1:0] d;
    begin
      d = CH_NUL;
      if (ch >= CH_ZERO && ch <= CH_NINE) begin
        d = ch - CH_ZERO;
      end else if (ch >= CH_UA && ch <= CH_UZ) begin
        d = ch - UPPER_OFS;
      end else if (ch >= CH_LA && ch <= CH_LZ) begin
        d = ch - LOWER_OFS;
      end else begin
        d = CHAR_BITS'(NOT_DIGIT);
      end
      return d[BASE_BITS-1:0];
    end
  endfunction

  function automatic logic [POSITION_BITS-1:0] pos_after(input logic [POSITION_BITS-1:0] idx);
    return (idx == POS_MAX) ? POS_MAX : idx + POSITION_BITS'(1);
  endfunction

endpackage
`default_nettype wire

### rtl/tuab_ctrl.sv
`default_nettype none
module tuab_ctrl
  import tuab_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic       string_start,
  input  wire logic       out_taken,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd,
  output logic            out_valid
);

  phase_t phase;
  phase_t phase_next;
  phase_t eff_phase;

  // A string start clears the parse before its own character is looked at.
  assign eff_phase = (accept && string_start) ? PH_SPACE : phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SPACE;
      out_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_taken) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    phase_next = phase;
    if (accept) begin
      phase_next = eff_phase;
      if (eff_phase != PH_DONE) begin
        if (status.is_nul) begin
          phase_next = PH_DONE;
        end else begin
          case (eff_phase)
            PH_SPACE, PH_FIRST: begin
              if (eff_phase == PH_SPACE && status.is_space) begin
                phase_next = PH_SPACE;
              end else if (eff_phase == PH_SPACE && status.is_sign) begin
                phase_next = PH_FIRST;
              end else if (status.is_zero_ch && (status.nb_zero || status.nb_hex)) begin
                phase_next = PH_ZERO;
              end else if (status.digit_ok && !status.overflow) begin
                phase_next = PH_DIGITS;
              end else begin
                phase_next = PH_DONE;
              end
            end
            PH_ZERO: begin
              if (status.is_x && (status.nb_zero || status.nb_hex)) begin
                phase_next = PH_HEXPFX;
              end else if (status.digit_ok && !status.overflow) begin
                phase_next = PH_DIGITS;
              end else begin
                phase_next = PH_DONE;
              end
            end
            PH_HEXPFX, PH_DIGITS: begin
              if (status.digit_ok && !status.overflow) begin
                phase_next = PH_DIGITS;
              end else begin
                phase_next = PH_DONE;
              end
            end
            default: phase_next = PH_DONE;
          endcase
        end
      end
    end
  end

  always_comb begin
    cmd = '0;
    cmd.base_src = BASE_FROM_REG;
    cmd.emit_kind = EMIT_FINISH;
    cmd.restart = accept && string_start;
    // The first-character base choice depends on the phase alone.
    cmd.use_first_base = (eff_phase == PH_SPACE) || (eff_phase == PH_FIRST);
    if (accept && eff_phase != PH_DONE) begin
      cmd.step = 1'b1;
      if (status.is_nul) begin
        cmd.emit = 1'b1;
      end else begin
        case (eff_phase)
          PH_SPACE, PH_FIRST: begin
            if (eff_phase == PH_SPACE && status.is_space) begin
              cmd.step = 1'b1;
            end else if (eff_phase == PH_SPACE && status.is_sign) begin
              cmd.set_sign = 1'b1;
            end else if (status.is_zero_ch && status.nb_zero) begin
              cmd.load_base = 1'b1;
              cmd.base_src = BASE_SET_OCT;
              cmd.mark_zero = 1'b1;
            end else if (status.is_zero_ch && status.nb_hex) begin
              cmd.load_base = 1'b1;
              cmd.mark_zero = 1'b1;
            end else begin
              cmd.load_base = 1'b1;
              if (!status.digit_ok) begin
                cmd.emit = 1'b1;
              end else if (status.overflow) begin
                cmd.emit = 1'b1;
                cmd.emit_kind = EMIT_OVERFLOW;
              end else begin
                cmd.take = 1'b1;
              end
            end
          end
          PH_ZERO, PH_HEXPFX, PH_DIGITS: begin
            if (eff_phase == PH_ZERO && status.is_x && (status.nb_zero || status.nb_hex)) begin
              cmd.load_base = 1'b1;
              cmd.base_src = BASE_SET_HEX;
            end else if (!status.digit_ok) begin
              cmd.emit = 1'b1;
            end else if (status.overflow) begin
              cmd.emit = 1'b1;
              cmd.emit_kind = EMIT_OVERFLOW;
            end else begin
              cmd.take = 1'b1;
            end
          end
          default: cmd.step = 1'b1;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

### rtl/tuab_dp.sv
`default_nettype none
module tuab_dp
  import tuab_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [BASE_BITS-1:0]   cfg_wdata,
  input  wire logic [CHAR_BITS-1:0]   char_code,
  input  wire dp_cmd_t                cmd,
  output dp_status_t                  status,
  output logic      [TDATA_BITS-1:0]  result
);

  logic [BASE_BITS-1:0]     number_base;
  logic [BASE_BITS-1:0]     base_in_use;
  logic [VALUE_BITS-1:0]    accumulator;
  logic                     negative_sign;
  logic [POSITION_BITS-1:0] char_index;
  logic [POSITION_BITS-1:0] last_digit_end;

  logic [BASE_BITS-1:0]     eff_base;
  logic [VALUE_BITS-1:0]    eff_acc;
  logic                     eff_neg;
  logic [POSITION_BITS-1:0] eff_idx;
  logic [POSITION_BITS-1:0] eff_last;
  logic [BASE_BITS-1:0]     first_base;
  logic [BASE_BITS-1:0]     work_base;
  logic [BASE_BITS-1:0]     digit;
  logic [PROD_BITS-1:0]     product;
  logic [POSITION_BITS-1:0] pos_next;
  logic [VALUE_BITS-1:0]    out_value;
  logic [POSITION_BITS-1:0] out_end;
  status_code_t             out_status;

  assign eff_base = cmd.restart ? '0 : base_in_use;
  assign eff_acc  = cmd.restart ? '0 : accumulator;
  assign eff_neg  = cmd.restart ? 1'b0 : negative_sign;
  assign eff_idx  = cmd.restart ? '0 : char_index;
  assign eff_last = cmd.restart ? '0 : last_digit_end;
  assign pos_next = pos_after(eff_idx);

  // A radix of one or above 36 maps to zero, which takes no digit at all.
  always_comb begin
    if (number_base == '0) begin
      first_base = BASE_DEC;
    end else if (number_base == BASE_BITS'(1) || number_base > BASE_MAX) begin
      first_base = '0;
    end else begin
      first_base = number_base;
    end
  end

  assign work_base = cmd.use_first_base ? first_base : eff_base;
  assign digit = digit_of(char_code);

  // Overflow shows as any bit above the value width after multiply and add.
  assign product = PROD_BITS'(eff_acc) * PROD_BITS'(work_base) + PROD_BITS'(digit);

  always_comb begin
    status.is_nul     = (char_code == CH_NUL);
    status.is_space   = (char_code == CH_SPACE) || (char_code >= CH_TAB && char_code <= CH_CR);
    status.is_sign    = (char_code == CH_PLUS) || (char_code == CH_MINUS);
    status.is_zero_ch = (char_code == CH_ZERO);
    status.is_x       = (char_code == CH_LX) || (char_code == CH_UX);
    status.nb_zero    = (number_base == '0);
    status.nb_hex     = (number_base == BASE_HEX);
    status.digit_ok   = (digit < work_base);
    status.overflow   = |product[PROD_BITS-1:VALUE_BITS];
  end

  always_comb begin
    if (cmd.emit_kind == EMIT_OVERFLOW) begin
      out_value  = '1;
      out_end    = eff_last;
      out_status = ST_OVERFLOW;
    end else if (eff_last == '0) begin
      out_value  = '0;
      out_end    = '0;
      out_status = ST_NODIGITS;
    end else begin
      out_value  = eff_neg ? ('0 - eff_acc) : eff_acc;
      out_end    = eff_last;
      out_status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      number_base    <= '0;
      base_in_use    <= '0;
      accumulator    <= '0;
      negative_sign  <= 1'b0;
      char_index     <= '0;
      last_digit_end <= '0;
    end else begin
      if (cfg_we) begin
        number_base <= cfg_wdata;
      end
      if (cmd.restart || cmd.step) begin
        base_in_use    <= eff_base;
        accumulator    <= eff_acc;
        negative_sign  <= eff_neg;
        char_index     <= cmd.step ? pos_next : eff_idx;
        last_digit_end <= eff_last;
        if (cmd.set_sign) begin
          negative_sign <= (char_code == CH_MINUS);
        end
        if (cmd.load_base) begin
          case (cmd.base_src)
            BASE_SET_OCT: base_in_use <= BASE_OCT;
            BASE_SET_HEX: base_in_use <= BASE_HEX;
            default:      base_in_use <= first_base;
          endcase
        end
        if (cmd.mark_zero) begin
          last_digit_end <= pos_next;
        end
        if (cmd.take) begin
          accumulator    <= product[VALUE_BITS-1:0];
          last_digit_end <= pos_next;
        end
      end
    end
    if (cmd.emit) begin
      result <= TDATA_BITS'({out_status, out_end, out_value});
    end
  end

endmodule
`default_nettype wire

### rtl/text_to_unsigned_any_base_top.sv
// A result is in the output register in the cycle after the character that ends the parse.
// Throughput: one character per cycle while the input is not stalled; the whole step (classify,
// multiply-add of the running value by the radix, overflow check) is combinational in the datapath.
// Input stalls only while a finished result waits in the single output register.
// Reset (rst, synchronous, active high) clears the parse and the output valid, and sets the
// radix register to zero, which selects the radix from the prefix.
`default_nettype none
module text_to_unsigned_any_base_top
  import tuab_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [BASE_BITS-1:0]  cfg_wdata,   // number_base
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [CHAR_BITS-1:0]  s_tdata,     // char_code
  input  wire logic                  s_tuser,     // string_start
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic      [TDATA_BITS-1:0] m_tdata      // value, end_position, status, zero fill
);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       accept;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  tuab_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .string_start (s_tuser),
    .out_taken    (m_tready),
    .status       (status),
    .cmd          (cmd),
    .out_valid    (m_tvalid)
  );

  tuab_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .char_code (s_tdata),
    .cmd       (cmd),
    .status    (status),
    .result    (m_tdata)
  );

endmodule
`default_nettype wire

### tb/tb_text_to_unsigned_any_base_top.sv
module tb_text_to_unsigned_any_base_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tuab_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SHOWN_MISMATCHES = 10;
  localparam int POS_LSB = VALUE_BITS;
  localparam int STATUS_LSB = VALUE_BITS + POSITION_BITS;
  localparam logic [VALUE_BITS-1:0] ALL_ONES = '1;
  localparam logic [CHAR_BITS-1:0] CH_LF = 8'h0a;
  localparam logic [CHAR_BITS-1:0] CH_VT = 8'h0b;
  localparam logic [CHAR_BITS-1:0] CH_FF = 8'h0c;
  localparam logic [CHAR_BITS-1:0] CH_TOP = 8'hff;

  typedef struct packed {
    logic [VALUE_BITS-1:0]    value;
    logic [POSITION_BITS-1:0] end_pos;
    status_code_t             status;
  } parse_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [BASE_BITS-1:0]  cfg_wdata = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [CHAR_BITS-1:0]  s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [TDATA_BITS-1:0] m_tdata;

  text_to_unsigned_any_base_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // Parser state as the block should hold it.
  logic [BASE_BITS-1:0]     radix_reg;
  phase_t                   phase_now;
  logic [BASE_BITS-1:0]     radix_now;
  logic [VALUE_BITS-1:0]    running_value;
  logic                     minus_seen;
  logic [POSITION_BITS-1:0] char_pos;
  logic [POSITION_BITS-1:0] digits_end;

  parse_result_t        pending_results[$];
  logic [CHAR_BITS-1:0] word_buf[$];

  bit src_gaps = 1'b1;
  bit snk_gaps = 1'b1;
  int sink_hold_cycles = 0;
  int mismatch_count = 0;
  int char_count = 0;
  int result_count = 0;
  int overflow_count = 0;
  int empty_count = 0;
  int radix_writes = 0;
  int cycle_count = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [POSITION_BITS-1:0] next_pos(input logic [POSITION_BITS-1:0] p);
    return (p == '1) ? p : p + 1'b1;
  endfunction

  function automatic logic [BASE_BITS-1:0] char_digit(input logic [CHAR_BITS-1:0] ch);
    if (ch >= CH_ZERO && ch <= CH_NINE) return BASE_BITS'(ch - CH_ZERO);
    if (ch >= CH_UA && ch <= CH_UZ) return BASE_BITS'(ch - CH_UA + 8'd10);
    if (ch >= CH_LA && ch <= CH_LZ) return BASE_BITS'(ch - CH_LA + 8'd10);
    return NOT_DIGIT;
  endfunction

  function automatic void restart_parse();
    phase_now = PH_SPACE;
    radix_now = '0;
    running_value = '0;
    minus_seen = 1'b0;
    char_pos = '0;
    digits_end = '0;
  endfunction

  function automatic void reset_model();
    radix_reg = '0;
    restart_parse();
  endfunction

  function automatic bit end_parse(output parse_result_t r);
    r = '0;
    if (digits_end == '0) begin
      r.status = ST_NODIGITS;
    end else begin
      r.value = minus_seen ? (VALUE_BITS'(0) - running_value) : running_value;
      r.end_pos = digits_end;
      r.status = ST_OK;
    end
    phase_now = PH_DONE;
    return 1'b1;
  endfunction

  function automatic bit add_digit(input logic [CHAR_BITS-1:0] ch,
                                   input logic [POSITION_BITS-1:0] pos,
                                   output parse_result_t r);
    logic [BASE_BITS-1:0]  d;
    logic [VALUE_BITS-1:0] radix_wide;
    logic [VALUE_BITS-1:0] cutoff;
    logic [VALUE_BITS-1:0] cutlim;
    r = '0;
    d = char_digit(ch);
    if (radix_now < 2 || radix_now > BASE_MAX || d >= radix_now) return end_parse(r);
    radix_wide = VALUE_BITS'(radix_now);
    cutoff = ALL_ONES / radix_wide;
    cutlim = ALL_ONES % radix_wide;
    if (running_value > cutoff || (running_value == cutoff && VALUE_BITS'(d) > cutlim)) begin
      r.value = ALL_ONES;
      r.end_pos = digits_end;
      r.status = ST_OVERFLOW;
      phase_now = PH_DONE;
      return 1'b1;
    end
    running_value = running_value * radix_wide + VALUE_BITS'(d);
    digits_end = next_pos(pos);
    phase_now = PH_DIGITS;
    return 1'b0;
  endfunction

  // Advances the parser by one character; returns 1 when the parse ends here.
  function automatic bit predict_char(input logic [CHAR_BITS-1:0] ch, input logic first,
                                      output parse_result_t r);
    logic [POSITION_BITS-1:0] pos;
    r = '0;
    if (first) restart_parse();
    if (phase_now == PH_DONE) return 1'b0;
    pos = char_pos;
    char_pos = next_pos(char_pos);
    if (ch == CH_NUL) return end_parse(r);
    case (phase_now)
      PH_SPACE, PH_FIRST: begin
        if (phase_now == PH_SPACE) begin
          if (ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR)) return 1'b0;
          if (ch == CH_PLUS || ch == CH_MINUS) begin
            minus_seen = (ch == CH_MINUS);
            phase_now = PH_FIRST;
            return 1'b0;
          end
        end
        if (radix_reg == 0) begin
          if (ch == CH_ZERO) begin
            radix_now = BASE_OCT;
            digits_end = next_pos(pos);
            phase_now = PH_ZERO;
            return 1'b0;
          end
          radix_now = BASE_DEC;
        end else if (radix_reg == 1 || radix_reg > BASE_MAX) begin
          radix_now = '0;
        end else begin
          radix_now = radix_reg;
          if (radix_reg == BASE_HEX && ch == CH_ZERO) begin
            digits_end = next_pos(pos);
            phase_now = PH_ZERO;
            return 1'b0;
          end
        end
        return add_digit(ch, pos, r);
      end
      PH_ZERO: begin
        if ((ch == CH_LX || ch == CH_UX) && (radix_reg == 0 || radix_reg == BASE_HEX)) begin
          radix_now = BASE_HEX;
          phase_now = PH_HEXPFX;
          return 1'b0;
        end
        return add_digit(ch, pos, r);
      end
      default: return add_digit(ch, pos, r);
    endcase
  endfunction

  task automatic flag_mismatch(input string what, input logic [VALUE_BITS-1:0] want,
                               input logic [VALUE_BITS-1:0] got);
    mismatch_count++;
    if (mismatch_count <= SHOWN_MISMATCHES)
      $display("%s mismatch: expected %0h, got %0h", what, want, got);
  endtask

  always @(posedge clk) begin
    parse_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("unrequested result value", '0, m_tdata[VALUE_BITS-1:0]);
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[VALUE_BITS-1:0] !== want.value)
          flag_mismatch("value", want.value, m_tdata[VALUE_BITS-1:0]);
        if (m_tdata[POS_LSB +: POSITION_BITS] !== want.end_pos)
          flag_mismatch("end position", VALUE_BITS'(want.end_pos),
                        VALUE_BITS'(m_tdata[POS_LSB +: POSITION_BITS]));
        if (m_tdata[STATUS_LSB +: STATUS_BITS] !== want.status)
          flag_mismatch("status", VALUE_BITS'(want.status),
                        VALUE_BITS'(m_tdata[STATUS_LSB +: STATUS_BITS]));
      end
    end
  end

  // Result side: a random stall before each transfer, or a long hold when one is requested.
  initial begin
    int wait_cycles;
    @(posedge clk);
    forever begin
      if (sink_hold_cycles > 0) begin
        wait_cycles = sink_hold_cycles;
        sink_hold_cycles = 0;
      end else begin
        wait_cycles = snk_gaps ? $urandom_range(0, 7) : 0;
      end
      if (wait_cycles > 0) begin
        m_tready <= 1'b0;
        for (int c = 0; c < wait_cycles; c++) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles with %0d results outstanding.",
             cycle_count, pending_results.size());
    $display("tb_text_to_unsigned_any_base_top: errors");
    $finish;
  end

  task automatic send_char(input logic [CHAR_BITS-1:0] ch, input logic first);
    int gap;
    parse_result_t r;
    gap = src_gaps ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= ch;
    s_tuser <= first;
    do @(posedge clk); while (!s_tready);
    char_count++;
    if (predict_char(ch, first, r)) begin
      pending_results.push_back(r);
      result_count++;
      if (r.status == ST_OVERFLOW) overflow_count++;
      if (r.status == ST_NODIGITS) empty_count++;
    end
  endtask

  task automatic send_word();
    foreach (word_buf[i]) send_char(word_buf[i], i == 0);
  endtask

  task automatic load_text(input string s);
    for (int i = 0; i < s.len(); i++) word_buf.push_back(s[i]);
  endtask

  // The register may only change once the parser has gone quiet.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_radix(input logic [BASE_BITS-1:0] b);
    wait_idle();
    cfg_wdata <= b;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    radix_reg = b;
    radix_writes++;
  endtask

  function automatic logic [CHAR_BITS-1:0] digit_char(input int d, input bit lower);
    if (d < 10) return CH_ZERO + CHAR_BITS'(d);
    return (lower ? CH_LA : CH_UA) + CHAR_BITS'(d - 10);
  endfunction

  function automatic logic [CHAR_BITS-1:0] blank_char();
    int r;
    r = $urandom_range(8, 13);
    return (r == 8) ? CH_SPACE : CHAR_BITS'(r);
  endfunction

  // A plausible string for the current radix, with some broken digits and junk.
  task automatic build_word();
    int eff;
    int n_dig;
    word_buf.delete();
    repeat ($urandom_range(0, 3)) word_buf.push_back(blank_char());
    case ($urandom_range(0, 3))
      0: word_buf.push_back(CH_PLUS);
      1: word_buf.push_back(CH_MINUS);
      default: ;
    endcase
    eff = radix_reg;
    if (radix_reg == 0) begin
      case ($urandom_range(0, 2))
        0: begin
          word_buf.push_back(CH_ZERO);
          word_buf.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
          eff = 16;
        end
        1: begin
          word_buf.push_back(CH_ZERO);
          eff = 8;
        end
        default: eff = 10;
      endcase
    end else if (radix_reg == 1 || radix_reg > BASE_MAX) begin
      eff = 36;
    end else if (radix_reg == BASE_HEX && $urandom_range(0, 2) == 0) begin
      word_buf.push_back(CH_ZERO);
      word_buf.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
    end
    n_dig = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 70) : $urandom_range(0, 8);
    repeat (n_dig) begin
      if ($urandom_range(0, 15) == 0) word_buf.push_back(CHAR_BITS'($urandom_range(0, 255)));
      else word_buf.push_back(digit_char($urandom_range(0, eff - 1), $urandom_range(0, 1)));
    end
    if ($urandom_range(0, 1)) word_buf.push_back(CH_NUL);
    else word_buf.push_back(CHAR_BITS'($urandom_range(0, 255)));
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) word_buf.push_back(CHAR_BITS'($urandom_range(0, 255)));
  endtask

  // The largest value in radix b, written out and then nudged either side of the limit.
  task automatic build_max_word(input int b);
    logic [VALUE_BITS-1:0] rest;
    logic [CHAR_BITS-1:0]  digs[$];
    word_buf.delete();
    if ($urandom_range(0, 2) == 0) word_buf.push_back(CH_MINUS);
    rest = ALL_ONES;
    while (rest != 0) begin
      digs.push_front(digit_char(int'(rest % b), $urandom_range(0, 1)));
      rest = rest / b;
    end
    case ($urandom_range(0, 3))
      1: digs[digs.size() - 1] = digit_char($urandom_range(0, b - 1), 1'b0);
      2: digs.push_back(digit_char($urandom_range(0, b - 1), 1'b1));
      3: void'(digs.pop_back());
      default: ;
    endcase
    foreach (digs[i]) word_buf.push_back(digs[i]);
    word_buf.push_back(CH_NUL);
  endtask

  task automatic test_directed();
    // Hex with an upper-case prefix and a plus sign.
    word_buf.delete();
    word_buf.push_back(CH_VT);
    load_text("+0X1f");
    word_buf.push_back(CH_NUL);
    send_word();
    // Negative octal ended by a non-ASCII byte; the trailing letter must be ignored.
    word_buf.delete();
    word_buf.push_back(CH_CR);
    load_text("-017");
    word_buf.push_back(CH_TOP);
    load_text("Z");
    send_word();
    // A hex prefix with no hex digit after it.
    word_buf.delete();
    word_buf.push_back(CH_TAB);
    load_text("0xg");
    send_word();
    // A lone sign, then an empty string.
    word_buf.delete();
    load_text("-");
    word_buf.push_back(CH_NUL);
    send_word();
    send_char(CH_NUL, 1'b1);
    // A string cut short by the start of the next one.
    word_buf.delete();
    word_buf.push_back(CH_LF);
    word_buf.push_back(CH_FF);
    load_text("9");
    send_word();
    send_char(digit_char(5, 1'b0), 1'b1);
    send_char(CH_NUL, 1'b0);
  endtask

  task automatic test_radix_sweep();
    logic [BASE_BITS-1:0] radix_list[$];
    int start_count;
    radix_list = '{2, 8, 10, 16, 36, 0, 1, 37, 63};
    repeat (3) radix_list.push_back(BASE_BITS'($urandom_range(2, 36)));
    foreach (radix_list[k]) begin
      write_radix(radix_list[k]);
      src_gaps = $urandom_range(0, 1);
      snk_gaps = $urandom_range(0, 1);
      start_count = char_count;
      while (char_count - start_count < 25) begin
        build_word();
        send_word();
      end
    end
    src_gaps = 1'b1;
    snk_gaps = 1'b1;
  endtask

  task automatic test_overflow_edge();
    int radix_list[$];
    radix_list = '{2, 7, 10, 16, 36};
    radix_list.push_back($urandom_range(2, 36));
    foreach (radix_list[k]) begin
      write_radix(BASE_BITS'(radix_list[k]));
      repeat (3) begin
        build_max_word(radix_list[k]);
        send_word();
      end
    end
  endtask

  // A finished result waits behind a stalled receiver until the input side stalls too.
  task automatic test_backpressure();
    write_radix(BASE_DEC);
    src_gaps = 1'b0;
    sink_hold_cycles = 400;
    repeat (20) begin
      send_char(digit_char($urandom_range(0, 9), 1'b0), 1'b1);
      send_char(CH_NUL, 1'b0);
    end
    src_gaps = 1'b1;
  endtask

  // Positions run well past what a byte can count.
  task automatic test_long_string();
    write_radix(BASE_DEC);
    src_gaps = 1'b0;
    word_buf.delete();
    repeat (300) word_buf.push_back(CH_SPACE);
    repeat (10) word_buf.push_back(CH_ZERO);
    word_buf.push_back(digit_char(9, 1'b0));
    word_buf.push_back(CH_NUL);
    send_word();
    word_buf.delete();
    src_gaps = 1'b1;
  endtask

  task automatic test_noise();
    write_radix(BASE_BITS'($urandom_range(0, 36)));
    repeat (100) send_char(CHAR_BITS'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
  endtask

  initial begin
    reset_model();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_radix_sweep();
    test_overflow_edge();
    test_backpressure();
    test_long_string();
    test_noise();
    wait_idle();
    repeat (8) @(posedge clk);
    $display("Sent %0d characters under %0d radix settings and checked %0d parse results.",
             char_count, radix_writes, result_count);
    $display("Of those, %0d overflowed and %0d found no digits; %0d mismatches seen.",
             overflow_count, empty_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("tb_text_to_unsigned_any_base_top: clean");
    end else begin
      $display("tb_text_to_unsigned_any_base_top: errors");
    end
    $finish;
  end

endmodule
